// ----- src/mdws_pkg.sv -----
`default_nettype none

package mdws_pkg;

  localparam int unsigned DirW      = 8;
  localparam int unsigned SpeedCfgW = 8;
  localparam int unsigned SqW       = 2 * DirW;
  localparam int unsigned MagSqW    = SqW + 1;
  localparam int unsigned WheelW    = 10;
  localparam int unsigned RotNum    = 11796;
  localparam int unsigned RotFracW  = 16;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef logic [DirW-1:0] dir_t;
  typedef logic signed [WheelW-1:0] wheel_t;

  typedef struct packed {
    logic              zero;
    logic [MagSqW-1:0] mag_sq;
    logic [SqW-1:0]    x_sq;
    logic [SqW-1:0]    y_sq;
  } item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ----- src/mdws_if.sv -----
`default_nettype none

interface mdws_dir_if import mdws_pkg::*; ();
  logic valid;
  logic ready;
  dir_t direction_x;
  dir_t direction_y;

  modport source (output valid, output direction_x, output direction_y, input ready);
  modport sink (input valid, input direction_x, input direction_y, output ready);
endinterface

interface mdws_spd_if import mdws_pkg::*; ();
  logic   valid;
  logic   ready;
  wheel_t left_rear_speed;
  wheel_t left_front_speed;
  wheel_t right_front_speed;
  wheel_t right_rear_speed;
  logic   zero_direction;

  modport source (
    output valid, output left_rear_speed, output left_front_speed,
    output right_front_speed, output right_rear_speed, output zero_direction,
    input ready
  );
  modport sink (
    input valid, input left_rear_speed, input left_front_speed,
    input right_front_speed, input right_rear_speed, input zero_direction,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/mecanum_direction_to_wheel_speeds.sv -----
`default_nettype none

// Turns a direction (x, y) into four mecanum wheel targets: the direction is scaled to the
// length held in the target_speed register, a fixed rotation term of 0.18 is mixed in, and
// each wheel value is truncated toward zero. A zero direction gives zero speeds and raises
// zero_direction. One transaction is accepted every cycle while the queue is not full; the
// scaling pipeline resolves one quotient bit per stage for FRACTION_BITS + 8 stages, and
// the wheel values are registered at the output. A waiting result holds the whole pipeline,
// and a four-entry queue in front of it keeps taking transactions until it is full.
// Write target_speed only while no transaction is in flight.
module mecanum_direction_to_wheel_speeds import mdws_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 target_speed_we_i,
  input  logic [SpeedCfgW-1:0] target_speed_i,
  mdws_dir_if.sink             dir_i,
  mdws_spd_if.source           spd_o
);

  logic [SqW-1:0] speed_sq_q;
  logic           fifo_push;
  logic           fifo_pop;
  fifo_ctrl_t     fifo_ctrl;
  fifo_stat_t     fifo_stat;
  item_t          push_item;
  item_t          head_item;

  assign fifo_ctrl = '{push: fifo_push, pop: fifo_pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_sq_q <= '0;
    end else if (target_speed_we_i) begin
      speed_sq_q <= SqW'(target_speed_i) * SqW'(target_speed_i);
    end
  end

  mdws_front u_front (
    .dir_i       (dir_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (fifo_push),
    .item_o      (push_item)
  );

  mdws_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (fifo_ctrl),
    .wdata_i (push_item),
    .rdata_o (head_item),
    .stat_o  (fifo_stat)
  );

  mdws_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .speed_sq_i  (speed_sq_q),
    .fifo_stat_i (fifo_stat),
    .item_i      (head_item),
    .pop_o       (fifo_pop),
    .spd_o       (spd_o)
  );

endmodule

`default_nettype wire

// ----- src/mdws_front.sv -----
`default_nettype none

module mdws_front import mdws_pkg::*; (
  mdws_dir_if.sink   dir_i,
  input  fifo_stat_t fifo_stat_i,
  output logic       push_o,
  output item_t      item_o
);

  logic [SqW-1:0] x_sq;
  logic [SqW-1:0] y_sq;

  assign x_sq = SqW'(dir_i.direction_x) * SqW'(dir_i.direction_x);
  assign y_sq = SqW'(dir_i.direction_y) * SqW'(dir_i.direction_y);

  assign dir_i.ready = !fifo_stat_i.full;
  assign push_o      = dir_i.valid && !fifo_stat_i.full;

  always_comb begin
    item_o.x_sq   = x_sq;
    item_o.y_sq   = y_sq;
    item_o.mag_sq = MagSqW'(x_sq) + MagSqW'(y_sq);
    item_o.zero   = (dir_i.direction_x == '0) && (dir_i.direction_y == '0);
  end

endmodule

`default_nettype wire

// ----- src/mdws_fifo.sv -----
`default_nettype none

module mdws_fifo import mdws_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fifo_ctrl_t ctrl_i,
  input  item_t      wdata_i,
  output item_t      rdata_o,
  output fifo_stat_t stat_o
);

  item_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wptr_q, wptr_d;
  logic [FifoPtrW-1:0] rptr_q, rptr_d;
  logic [FifoCntW-1:0] count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign stat_o.full  = (count_q == FifoCntW'(FifoDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = ctrl_i.push && !stat_o.full;
  assign do_pop       = ctrl_i.pop && !stat_o.empty;
  assign rdata_o      = mem_q[rptr_q];

  always_comb begin
    wptr_d  = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = do_pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/mdws_back.sv -----
`default_nettype none

module mdws_back import mdws_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SqW-1:0]    speed_sq_i,
  input  fifo_stat_t        fifo_stat_i,
  input  item_t             item_i,
  output logic              pop_o,
  mdws_spd_if.source        spd_o
);

  localparam int unsigned QW = DirW + FRACTION_BITS;
  localparam int unsigned PW = 2 * SqW;
  localparam int unsigned RW = 2 * SqW + 2 * FRACTION_BITS;
  localparam int unsigned UW = QW + MagSqW;
  localparam int unsigned DW = 2 * QW + MagSqW + 1;
  localparam int unsigned SW = QW + 3;
  localparam logic [QW-1:0] Rot = (FRACTION_BITS >= RotFracW) ?
      QW'(longint'(RotNum) << (FRACTION_BITS - RotFracW)) :
      QW'(longint'(RotNum) >> (RotFracW - FRACTION_BITS));

  logic              advance;
  logic [QW:0]       valid_q;
  logic              zero_q   [QW+1];
  logic [MagSqW-1:0] mag_sq_q [QW+1];
  logic [RW-1:0]     rem_q    [2][QW+1];
  logic [UW-1:0]     acc_q    [2][QW+1];
  logic [QW-1:0]     quo_q    [2][QW+1];
  logic              out_valid_q;

  function automatic wheel_t trunc_speed(input logic signed [SW-1:0] v);
    logic [SW-1:0] mag;
    logic [SW-1:0] whole;
    mag   = v[SW-1] ? SW'(-v) : SW'(v);
    whole = mag >> FRACTION_BITS;
    return v[SW-1] ? WheelW'(-whole) : WheelW'(whole);
  endfunction

  assign advance     = !out_valid_q || spd_o.ready;
  assign pop_o       = advance && !fifo_stat_i.empty;
  assign spd_o.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      valid_q     <= {valid_q[QW-1:0], !fifo_stat_i.empty};
      out_valid_q <= valid_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      zero_q[0]      <= item_i.zero;
      mag_sq_q[0]    <= item_i.mag_sq;
      rem_q[0][0]    <= {PW'(speed_sq_i) * PW'(item_i.x_sq), {(2 * FRACTION_BITS){1'b0}}};
      rem_q[1][0]    <= {PW'(speed_sq_i) * PW'(item_i.y_sq), {(2 * FRACTION_BITS){1'b0}}};
      acc_q[0][0]    <= '0;
      acc_q[1][0]    <= '0;
      quo_q[0][0]    <= '0;
      quo_q[1][0]    <= '0;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    localparam int unsigned K = QW - j;

    always_ff @(posedge clk_i) begin
      if (advance) begin
        zero_q[j]   <= zero_q[j-1];
        mag_sq_q[j] <= mag_sq_q[j-1];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DW-1:0] trial;
      logic          take;

      assign trial = (DW'(acc_q[l][j-1]) << (K + 1)) + (DW'(mag_sq_q[j-1]) << (2 * K));
      assign take  = DW'(rem_q[l][j-1]) >= trial;

      always_ff @(posedge clk_i) begin
        if (advance) begin
          if (take) begin
            rem_q[l][j] <= rem_q[l][j-1] - RW'(trial);
            acc_q[l][j] <= acc_q[l][j-1] + (UW'(mag_sq_q[j-1]) << K);
            quo_q[l][j] <= quo_q[l][j-1] | (QW'(1) << K);
          end else begin
            rem_q[l][j] <= rem_q[l][j-1];
            acc_q[l][j] <= acc_q[l][j-1];
            quo_q[l][j] <= quo_q[l][j-1];
          end
        end
      end
    end
  end

  logic signed [SW-1:0] vx;
  logic signed [SW-1:0] vy;
  logic signed [SW-1:0] rot;

  assign vx  = $signed(SW'(quo_q[0][QW]));
  assign vy  = $signed(SW'(quo_q[1][QW]));
  assign rot = $signed(SW'(Rot));

  always_ff @(posedge clk_i) begin
    if (advance) begin
      spd_o.zero_direction <= zero_q[QW];
      if (zero_q[QW]) begin
        spd_o.left_rear_speed   <= '0;
        spd_o.left_front_speed  <= '0;
        spd_o.right_front_speed <= '0;
        spd_o.right_rear_speed  <= '0;
      end else begin
        spd_o.left_rear_speed   <= trunc_speed(vy - vx - rot);
        spd_o.left_front_speed  <= trunc_speed(vx + vy - rot);
        spd_o.right_front_speed <= trunc_speed(vy - vx + rot);
        spd_o.right_rear_speed  <= trunc_speed(vx + vy + rot);
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/mdws_checker.sv -----
`default_nettype none

module mdws_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [9:0]  left_rear_i,
  input logic signed [9:0]  left_front_i,
  input logic signed [9:0]  right_front_i,
  input logic signed [9:0]  right_rear_i,
  input logic               zero_dir_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(left_rear_i)
      && $stable(left_front_i) && $stable(right_front_i) && $stable(right_rear_i)
      && $stable(zero_dir_i))
    else $error("Result changed while stalled.");

  a_zero_speeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_dir_i |-> left_rear_i == 10'sd0 && left_front_i == 10'sd0
      && right_front_i == 10'sd0 && right_rear_i == 10'sd0)
    else $error("Zero direction with nonzero wheel speeds.");

  a_rot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> right_rear_i >= left_front_i && right_front_i >= left_rear_i)
    else $error("Rotation term mixed with the wrong sign.");

  a_no_valid_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("Result valid directly after reset.");

endmodule

bind mecanum_direction_to_wheel_speeds mdws_checker u_mdws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (spd_o.valid),
  .out_ready_i   (spd_o.ready),
  .left_rear_i   (spd_o.left_rear_speed),
  .left_front_i  (spd_o.left_front_speed),
  .right_front_i (spd_o.right_front_speed),
  .right_rear_i  (spd_o.right_rear_speed),
  .zero_dir_i    (spd_o.zero_direction)
);

`default_nettype wire
